/* src/psd_pkg.sv */
// ---------------------------------------------------------------------------
// psd_pkg
// Shared types, byte codes and result kinds of the panel display stream decoder.
// ---------------------------------------------------------------------------
package psd_pkg;

    // Result kinds
    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_OPTION = 3'd1;
    localparam logic [2:0] KIND_WORD6  = 3'd2;
    localparam logic [2:0] KIND_WORD7  = 3'd3;
    localparam logic [2:0] KIND_UNK    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MODEL   = 1'b0;
    localparam logic CFG_SILENCE = 1'b1;

    // Model select codes
    localparam logic [1:0] MODEL_AUTO   = 2'd0;
    localparam logic [1:0] MODEL_SINGLE = 2'd1;

    // Stream byte codes
    localparam logic [7:0] BYTE_COMMIT   = 8'h02;
    localparam logic [7:0] BYTE_TEXT3    = 8'h03;
    localparam logic [7:0] BYTE_TEXT4    = 8'h04;
    localparam logic [7:0] BYTE_WORD6    = 8'h06;
    localparam logic [7:0] BYTE_WORD7    = 8'h07;
    localparam logic [7:0] BYTE_FLASH    = 8'h0B;
    localparam logic [7:0] BYTE_TEXTD    = 8'h0D;
    localparam logic [7:0] BYTE_IDENT    = 8'h0F;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_TEXT_MAX = 8'hB0;
    localparam logic [7:0] BYTE_TWO_MARK = 8'hB7;
    localparam logic [7:0] FLASH_BIT     = 8'h80;

    localparam logic [9:0] SILENCE_MAX   = 10'h3FF;
    localparam logic [9:0] SILENCE_RESET = 10'd50;

    // One classified input word
    typedef struct packed {
        logic       tick;
        logic [7:0] data;
        logic       ctrl;   // 0x00..0x0F
        logic       text;   // 0x20..0xB0
    } t_item;

    // One result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  position;
        logic [15:0] value;
        logic        flash;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEC, ST_START, ST_PEND, ST_PUT, ST_FILL, ST_PUTW,
        ST_CMT, ST_CRD, ST_CEM, ST_CFIN, ST_CPR, ST_CPW, ST_END
    } t_state;

    typedef enum logic [1:0] {
        CONT_NONE, CONT_START, CONT_PEND
    } t_cont;

    function automatic t_state cont_state(input t_cont c);
        t_state s;
        case (c)
            CONT_START: s = ST_START;
            CONT_PEND:  s = ST_PEND;
            default:    s = ST_END;
        endcase
        return s;
    endfunction

    function automatic logic is_option(input logic [7:0] c);
        return (c == 8'h06) || (c == 8'h07) || (c == 8'h08) || (c == 8'h09) ||
               (c == 8'h0A) || (c == 8'h0E);
    endfunction

endpackage

/* src/panel_display_stream_decoder.sv */
// ---------------------------------------------------------------------------
// panel_display_stream_decoder
// Front-panel display stream decoder: bytes and 1 ms ticks in, line
// characters, option bytes, header words and unknown messages out.
// ---------------------------------------------------------------------------
// A two-entry queue takes input words while the sequencer works on an earlier
// one; the input stalls once both entries are full. Padding up to an overwrite
// offset writes one space at a time. A commit that delivers a text line reads
// each character from the line memory and then emits it as a result, and
// opening an overwrite line copies the last line character by character
// (read, then write); a stalled output holds the sequencer. Results leave
// through an output register; one result is held back so that the final one
// of each input word can be marked last.
module panel_display_stream_decoder #(
    parameter int LINE_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [5:0]  o_position,
    output logic [15:0] o_value,
    output logic        o_flash,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    logic           q_valid, q_pop;
    psd_pkg::t_item q_item;
    psd_pkg::t_res  res;

    psd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_cmd(i_cmd), .i_rx_byte(i_rx_byte),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    psd_engine #(.LINE_LEN(LINE_LEN)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_res(res)
    );

    assign o_kind     = res.kind;
    assign o_position = res.position;
    assign o_value    = res.value;
    assign o_flash    = res.flash;
    assign o_last     = res.last;

endmodule

/* src/psd_front.sv */
// ---------------------------------------------------------------------------
// psd_front
// Accepts input words, classifies bytes and queues them (two entries).
// ---------------------------------------------------------------------------
module psd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_cmd,
    input  logic [7:0]    i_rx_byte,
    output logic          o_q_valid,
    output psd_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    psd_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    psd_pkg::t_item item;

    // Classify the incoming byte
    always_comb begin
        item.tick = i_cmd;
        item.data = i_rx_byte;
        item.ctrl = (i_rx_byte <= psd_pkg::BYTE_IDENT);
        item.text = (i_rx_byte >= psd_pkg::BYTE_SPACE) && (i_rx_byte <= psd_pkg::BYTE_TEXT_MAX);
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    // Hold queued words
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

endmodule

/* src/psd_engine.sv */
// ---------------------------------------------------------------------------
// psd_engine
// Sequencer that carries out one queued word: message parsing, line assembly
// in a two-bank line memory, commits and result delivery.
// ---------------------------------------------------------------------------
module psd_engine #(
    parameter int LINE_LEN = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [9:0]     i_cfg_data,
    input  logic           i_q_valid,
    input  psd_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output psd_pkg::t_res  o_res
);
    localparam int IW = $clog2(LINE_LEN);
    localparam int AW = IW + 1;
    localparam logic [5:0] LEN_MAX = 6'(LINE_LEN);

    // Control state
    psd_pkg::t_state r_st, n_st;
    psd_pkg::t_cont  r_cont, n_cont;
    logic [1:0]      r_model;
    logic [9:0]      r_limit;
    logic [5:0]      r_i, n_i;
    logic [5:0]      r_line_len, n_line_len;
    logic [5:0]      r_lat_len, n_lat_len;
    logic            r_lat_bank, n_lat_bank;
    logic [15:0]     r_msg, n_msg;
    logic [7:0]      r_pend, n_pend;
    logic [1:0]      r_exp, n_exp;
    logic [5:0]      r_ow, n_ow;
    logic            r_flashing, n_flashing;
    logic            r_curf, n_curf;
    logic            r_lastf, n_lastf;
    logic            r_valid, n_valid;
    logic            r_seen, n_seen;
    logic            r_two, n_two;
    logic [7:0]      r_opt [16];
    logic [7:0]      n_opt [16];
    logic [15:0]     r_pw [2];
    logic [15:0]     n_pw [2];
    logic [1:0]      r_pm [2];
    logic [1:0]      n_pm [2];
    logic [9:0]      r_sil, n_sil;
    logic            r_hv, n_hv;
    logic            r_ov;

    // Payload state
    psd_pkg::t_item  r_item;
    logic [7:0]      r_lo, n_lo;
    logic [7:0]      r_pc, n_pc;
    logic            r_fl, n_fl;
    logic [7:0]      r_b0, r_b1;
    psd_pkg::t_res   r_held, n_held;
    psd_pkg::t_res   r_out;
    logic [7:0]      r_mem [2**AW];
    logic [7:0]      r_rdata;

    // Memory and result controls
    logic            mem_we;
    logic [5:0]      mem_widx;
    logic [7:0]      mem_wdata;
    logic            mem_rbank;
    logic [5:0]      mem_ridx;
    logic            em;
    psd_pkg::t_res   em_res;
    logic            can_push, em_ok, push, push_last;
    logic            line_bank;

    assign line_bank   = ~r_lat_bank;
    assign can_push    = !r_ov || !i_out_stall;
    assign em_ok       = !r_hv || can_push;
    assign o_out_valid = r_ov;
    assign o_res       = r_out;

    // Next state
    always_comb begin
        logic [9:0]  sil_inc;
        logic        start;
        logic [15:0] msg_v;
        logic [7:0]  ch_v;
        logic [3:0]  lo;
        logic        slot;
        logic [1:0]  mark;
        logic [15:0] word;
        logic        single;
        logic [7:0]  ch;

        n_st = r_st; n_cont = r_cont; n_i = r_i;
        n_line_len = r_line_len; n_lat_len = r_lat_len; n_lat_bank = r_lat_bank;
        n_msg = r_msg; n_pend = r_pend; n_exp = r_exp; n_ow = r_ow;
        n_flashing = r_flashing; n_curf = r_curf; n_lastf = r_lastf;
        n_valid = r_valid; n_seen = r_seen; n_two = r_two;
        n_opt = r_opt; n_pw = r_pw; n_pm = r_pm; n_sil = r_sil; n_hv = r_hv;
        n_lo = r_lo; n_pc = r_pc; n_fl = r_fl; n_held = r_held;
        mem_we = 1'b0; mem_widx = r_line_len; mem_wdata = r_pc;
        mem_rbank = line_bank; mem_ridx = r_i;
        em = 1'b0; em_res = '0; o_q_pop = 1'b0; push = 1'b0; push_last = 1'b0;
        ch = r_item.data;
        lo = r_msg[3:0];
        slot = lo[0];
        mark = (r_line_len > 6'd2) ? 2'd3 : r_line_len[1:0];
        word = (r_line_len >= 6'd2) ? {r_b0, r_b1} :
               (r_line_len == 6'd1) ? {8'd0, r_b0} : 16'd0;
        sil_inc = (r_sil < psd_pkg::SILENCE_MAX) ? r_sil + 10'd1 : r_sil;
        start = 1'b0; msg_v = r_msg; ch_v = ch;
        single = (r_model == psd_pkg::MODEL_SINGLE) ? 1'b1 :
                 (r_model > psd_pkg::MODEL_SINGLE) ? 1'b0 : !r_two;

        case (r_st)
            // Take the next queued word
            psd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_st    = psd_pkg::ST_DEC;
                end
            end
            // Decode a tick or a byte
            psd_pkg::ST_DEC: begin
                n_cont = psd_pkg::CONT_NONE;
                if (r_item.tick) begin
                    n_sil = sil_inc;
                    if (r_msg != 16'd0 && sil_inc > r_limit) n_st = psd_pkg::ST_CMT;
                    else n_st = psd_pkg::ST_END;
                end else begin
                    n_sil  = 10'd0;
                    n_seen = 1'b1;
                    if (ch == psd_pkg::BYTE_TWO_MARK && !r_seen &&
                        r_model == psd_pkg::MODEL_AUTO) n_two = 1'b1;
                    start = r_item.ctrl && r_exp == 2'd0 && r_pend == 8'd0;
                    if (r_exp != 2'd0 && r_line_len >= {4'd0, r_exp}) start = 1'b1;
                    if (r_pend == 8'd0 && start) begin
                        if (ch == psd_pkg::BYTE_COMMIT) begin
                            n_st = psd_pkg::ST_CMT;
                        end else if (ch != psd_pkg::BYTE_IDENT) begin
                            if (ch != psd_pkg::BYTE_FLASH) begin
                                n_cont = psd_pkg::CONT_START;
                                n_st   = psd_pkg::ST_CMT;
                            end else begin
                                n_st = psd_pkg::ST_START;
                            end
                        end else begin
                            n_st = psd_pkg::ST_END;
                        end
                    end else if (r_pend != 8'd0) begin
                        n_lo   = r_pend;
                        n_pend = 8'd0;
                        if (r_pend == psd_pkg::BYTE_FLASH) begin
                            n_flashing = (ch != 8'd0);
                            n_st       = psd_pkg::ST_END;
                        end else begin
                            n_cont = psd_pkg::CONT_PEND;
                            n_st   = psd_pkg::ST_CMT;
                        end
                    end else begin
                        if (r_msg == 16'd0 && r_item.text) msg_v = 16'h0004;
                        n_msg = msg_v;
                        if (msg_v != 16'd0) begin
                            if (r_flashing && msg_v[7:0] == psd_pkg::BYTE_TEXT4) begin
                                ch_v   = ch | psd_pkg::FLASH_BIT;
                                n_curf = 1'b1;
                            end
                            n_pc = ch_v;
                            n_st = psd_pkg::ST_PUT;
                        end else begin
                            n_st = psd_pkg::ST_END;
                        end
                    end
                end
            end
            // Open a message after the start byte
            psd_pkg::ST_START: begin
                if (single) begin
                    n_pend = ch;
                end else if (ch == psd_pkg::BYTE_WORD6 || ch == psd_pkg::BYTE_WORD7) begin
                    n_exp = 2'd2;
                    n_msg = {8'd0, ch};
                end else begin
                    n_pend = ch;
                end
                n_st = psd_pkg::ST_END;
            end
            // Second byte of a pending command
            psd_pkg::ST_PEND: begin
                if (psd_pkg::is_option(r_lo)) begin
                    if (r_opt[r_lo[3:0]] != ch) begin
                        if (em_ok) begin
                            n_opt[r_lo[3:0]] = ch;
                            em = 1'b1;
                            em_res.kind = psd_pkg::KIND_OPTION;
                            em_res.position = r_lo[5:0];
                            em_res.value = {8'd0, ch};
                            n_msg = 16'd0;
                            n_st = psd_pkg::ST_END;
                        end
                    end else begin
                        n_msg = 16'd0;
                        n_st  = psd_pkg::ST_END;
                    end
                end else if (r_lo == psd_pkg::BYTE_TEXTD || r_lo == psd_pkg::BYTE_TEXT4 ||
                             r_lo == psd_pkg::BYTE_TEXT3) begin
                    n_msg = 16'h0004;
                    n_st  = psd_pkg::ST_END;
                    if (ch < psd_pkg::BYTE_SPACE) begin
                        if (ch != 8'd0) begin
                            n_line_len = r_lat_len;
                            n_i = 6'd0;
                            if (r_lat_len != 6'd0) n_st = psd_pkg::ST_CPR;
                        end else begin
                            n_line_len = 6'd0;
                        end
                        n_ow   = ch[5:0];
                        n_curf = r_lastf;
                    end else begin
                        mem_we     = 1'b1;
                        mem_widx   = 6'd0;
                        mem_wdata  = ch;
                        n_line_len = 6'd1;
                        n_ow       = 6'd0;
                    end
                end else begin
                    n_msg = {ch, r_lo};
                    n_st  = psd_pkg::ST_END;
                end
            end
            // Place one character
            psd_pkg::ST_PUT: begin
                n_st = psd_pkg::ST_END;
                if (r_ow != 6'd0) begin
                    if (r_ow < LEN_MAX) begin
                        if (r_line_len <= r_ow) begin
                            n_st = psd_pkg::ST_FILL;
                        end else begin
                            mem_we = 1'b1; mem_widx = r_ow;
                            n_ow = r_ow + 6'd1;
                        end
                    end
                end else if (r_line_len < LEN_MAX) begin
                    mem_we = 1'b1;
                    n_line_len = r_line_len + 6'd1;
                end
            end
            // Pad with spaces up to the overwrite offset
            psd_pkg::ST_FILL: begin
                mem_we = 1'b1; mem_wdata = psd_pkg::BYTE_SPACE;
                n_line_len = r_line_len + 6'd1;
                if (r_line_len == r_ow) n_st = psd_pkg::ST_PUTW;
            end
            psd_pkg::ST_PUTW: begin
                mem_we = 1'b1; mem_widx = r_ow;
                n_ow = r_ow + 6'd1;
                n_st = psd_pkg::ST_END;
            end
            // Commit the open message
            psd_pkg::ST_CMT: begin
                if (r_msg == 16'd0) begin
                    n_st = psd_pkg::cont_state(r_cont);
                end else if (em_ok) begin
                    n_msg = 16'd0; n_exp = 2'd0; n_ow = 6'd0;
                    if (lo == psd_pkg::BYTE_TEXTD[3:0] || lo == psd_pkg::BYTE_TEXT4[3:0]) begin
                        n_fl = r_curf;
                        n_i  = 6'd0;
                        n_st = (r_line_len != 6'd0) ? psd_pkg::ST_CRD : psd_pkg::ST_CFIN;
                    end else begin
                        if (lo == psd_pkg::BYTE_WORD6[3:0] || lo == psd_pkg::BYTE_WORD7[3:0]) begin
                            if (!(mark == r_pm[slot] && word == r_pw[slot])) begin
                                n_pm[slot] = mark;
                                n_pw[slot] = word;
                                if (mark == 2'd2) begin
                                    if (slot || r_valid) begin
                                        n_lastf = r_curf;
                                        n_curf  = 1'b0;
                                    end
                                    em = 1'b1;
                                    em_res.kind = slot ? psd_pkg::KIND_WORD7 : psd_pkg::KIND_WORD6;
                                    em_res.position = {2'd0, lo};
                                    em_res.value = word;
                                end else if (r_valid) begin
                                    em = 1'b1;
                                    em_res.kind = psd_pkg::KIND_UNK;
                                    em_res.position = {2'd0, lo};
                                    em_res.value = r_msg;
                                end
                            end
                        end else if (r_valid) begin
                            em = 1'b1;
                            em_res.kind = psd_pkg::KIND_UNK;
                            em_res.position = {2'd0, lo};
                            em_res.value = r_msg;
                        end
                        n_line_len = 6'd0;
                        n_st = psd_pkg::cont_state(r_cont);
                    end
                end
            end
            // Read and deliver the line characters
            psd_pkg::ST_CRD: begin
                n_st = psd_pkg::ST_CEM;
            end
            psd_pkg::ST_CEM: begin
                if (em_ok) begin
                    em = 1'b1;
                    em_res.kind = psd_pkg::KIND_CHAR;
                    em_res.position = r_i;
                    em_res.value = {8'd0, r_rdata};
                    em_res.flash = r_fl;
                    n_i = r_i + 6'd1;
                    n_st = (r_i + 6'd1 < r_line_len) ? psd_pkg::ST_CRD : psd_pkg::ST_CFIN;
                end
            end
            psd_pkg::ST_CFIN: begin
                if (r_line_len != 6'd0) begin
                    n_lat_bank = ~r_lat_bank;
                    n_lat_len  = r_line_len;
                end
                n_valid = 1'b1; n_lastf = r_fl; n_curf = 1'b0;
                n_line_len = 6'd0;
                n_st = psd_pkg::cont_state(r_cont);
            end
            // Copy the last line into the working bank
            psd_pkg::ST_CPR: begin
                mem_rbank = r_lat_bank;
                n_st = psd_pkg::ST_CPW;
            end
            psd_pkg::ST_CPW: begin
                mem_we = 1'b1; mem_widx = r_i; mem_wdata = r_rdata;
                n_i = r_i + 6'd1;
                n_st = (r_i + 6'd1 < r_lat_len) ? psd_pkg::ST_CPR : psd_pkg::ST_END;
            end
            // Release the held result marked last
            psd_pkg::ST_END: begin
                if (!r_hv) begin
                    n_st = psd_pkg::ST_IDLE;
                end else if (can_push) begin
                    push = 1'b1; push_last = 1'b1; n_hv = 1'b0;
                    n_st = psd_pkg::ST_IDLE;
                end
            end
            default: n_st = psd_pkg::ST_IDLE;
        endcase

        // Hold the newest result; move the previous one out
        if (em) begin
            if (r_hv) push = 1'b1;
            n_hv   = 1'b1;
            n_held = em_res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= psd_pkg::ST_IDLE; r_cont <= psd_pkg::CONT_NONE;
            r_model <= psd_pkg::MODEL_AUTO; r_limit <= psd_pkg::SILENCE_RESET;
            r_i <= 6'd0; r_line_len <= 6'd0; r_lat_len <= 6'd0; r_lat_bank <= 1'b0;
            r_msg <= 16'd0; r_pend <= 8'd0; r_exp <= 2'd0; r_ow <= 6'd0;
            r_flashing <= 1'b0; r_curf <= 1'b0; r_lastf <= 1'b0;
            r_valid <= 1'b0; r_seen <= 1'b0; r_two <= 1'b0;
            for (int k = 0; k < 16; k++) r_opt[k] <= 8'd0;
            for (int k = 0; k < 2; k++) begin
                r_pw[k] <= 16'd0;
                r_pm[k] <= 2'd0;
            end
            r_sil <= 10'd0; r_hv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cont <= n_cont;
            if (i_cfg_we && i_cfg_index == psd_pkg::CFG_MODEL) r_model <= i_cfg_data[1:0];
            if (i_cfg_we && i_cfg_index == psd_pkg::CFG_SILENCE) r_limit <= i_cfg_data;
            r_i <= n_i; r_line_len <= n_line_len; r_lat_len <= n_lat_len;
            r_lat_bank <= n_lat_bank; r_msg <= n_msg; r_pend <= n_pend; r_exp <= n_exp;
            r_ow <= n_ow; r_flashing <= n_flashing; r_curf <= n_curf; r_lastf <= n_lastf;
            r_valid <= n_valid; r_seen <= n_seen; r_two <= n_two;
            r_opt <= n_opt; r_pw <= n_pw; r_pm <= n_pm; r_sil <= n_sil; r_hv <= n_hv;
            if (push) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    // Payload registers and line memory
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_item <= i_q_item;
        r_lo <= n_lo; r_pc <= n_pc; r_fl <= n_fl; r_held <= n_held;
        if (push) begin
            r_out <= psd_pkg::t_res'{kind: r_held.kind, position: r_held.position,
                                     value: r_held.value, flash: r_held.flash,
                                     last: push_last};
        end
        if (mem_we) begin
            r_mem[{line_bank, mem_widx[IW-1:0]}] <= mem_wdata;
            if (mem_widx == 6'd0) r_b0 <= mem_wdata;
            if (mem_widx == 6'd1) r_b1 <= mem_wdata;
        end
        r_rdata <= r_mem[{mem_rbank, mem_ridx[IW-1:0]}];
    end

endmodule

/* src/psd_checker.sv */
// ---------------------------------------------------------------------------
// psd_checker
// Port-level checks of the panel display stream decoder.
// ---------------------------------------------------------------------------
module psd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [15:0] o_value,
    input logic        o_flash,
    input logic        o_last
);
    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_value) && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

    // Kinds stay in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= psd_pkg::KIND_UNK)
        else $error("bad result kind");

    // Only line characters carry flash
    a_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != psd_pkg::KIND_CHAR |-> !o_flash)
        else $error("flash on non-character result");

endmodule

bind panel_display_stream_decoder psd_checker u_psd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_kind(o_kind), .o_value(o_value),
    .o_flash(o_flash), .o_last(o_last)
);
